// ===== sv/mcpt_pkg.sv =====
package mcpt_pkg;

   localparam int CHANNELS_DEF = 8;

   localparam int TIME_W = 32;
   localparam int MASK_W = 8;
   localparam int OP_W   = 2;
   localparam int CH_W   = 3;

   localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
   localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic sub;
   } alu_ctrl_type;

endpackage

// ===== sv/mcpt_alu.sv =====
module mcpt_alu (
   input  mcpt_pkg::alu_ctrl_type          ctrl,
   input  logic [mcpt_pkg::TIME_W-1:0]     opa,
   input  logic [mcpt_pkg::TIME_W-1:0]     opb,
   output logic [mcpt_pkg::TIME_W-1:0]     result,
   output logic                            not_neg
);

   // add for deadline = now + width, subtract for the wrap-safe now - deadline test
   always_comb begin
      if (ctrl.sub == mcpt_pkg::ALU_SUB) begin
         result = opa - opb;
      end else begin
         result = opa + opb;
      end
      not_neg = ~result[mcpt_pkg::TIME_W-1];
   end

endmodule

// ===== sv/multi_channel_pulse_timer_unit.sv =====
// Arm, disarm and unused codes: the word goes from idle straight to the finish step.
// Tick: the word goes to the scan, where one shared subtractor visits each channel
// in turn, one channel per cycle, and then to the finish step.
// Input accepted only in idle, so a new word is taken only after the last one's result
// is loaded; a stalled result holds the finish step.
// Synchronous active-high reset: all channels inactive, rsp_valid low, no result pending.
module multi_channel_pulse_timer_unit #(
   parameter int CHANNELS = mcpt_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mcpt_pkg::OP_W-1:0]       req_operation,
   input  logic [mcpt_pkg::CH_W-1:0]       req_channel,
   input  logic [mcpt_pkg::TIME_W-1:0]     req_pulse_width,
   input  logic [mcpt_pkg::TIME_W-1:0]     req_now_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mcpt_pkg::MASK_W-1:0]     rsp_trigger_mask,
   output logic [mcpt_pkg::MASK_W-1:0]     rsp_expired_mask
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [CHANNELS-1:0]               active_ff, active_in;
   logic [CHANNELS-1:0]               expired_ff, expired_in;
   logic [mcpt_pkg::TIME_W-1:0]       now_ff;
   logic [mcpt_pkg::TIME_W-1:0]       deadline_ff [CHANNELS];
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mcpt_pkg::MASK_W-1:0]       trig_ff, exp_ff;

   logic                              accept;
   logic                              ch_ok;
   logic [IDX_W-1:0]                  ch_idx;
   logic                              out_free;

   mcpt_pkg::alu_ctrl_type            alu_ctrl;
   logic [mcpt_pkg::TIME_W-1:0]       alu_a, alu_b, alu_res;
   logic                              alu_not_neg;

   mcpt_alu u_alu (
      .ctrl    (alu_ctrl),
      .opa     (alu_a),
      .opb     (alu_b),
      .result  (alu_res),
      .not_neg (alu_not_neg)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ch_ok     = (int'(req_channel) < CHANNELS);
   assign ch_idx    = IDX_W'(req_channel);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // idle: arm computes the deadline; scan: wrap-safe compare of the visited channel
   always_comb begin
      if (state_ff == S_SCAN) begin
         alu_ctrl.sub = mcpt_pkg::ALU_SUB;
         alu_a        = now_ff;
         alu_b        = deadline_ff[idx_ff];
      end else begin
         alu_ctrl.sub = mcpt_pkg::ALU_ADD;
         alu_a        = req_now_time;
         alu_b        = req_pulse_width;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      expired_in   = expired_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               expired_in = '0;
               idx_in     = '0;
               state_in   = S_FIN;
               case (req_operation)
                  mcpt_pkg::OP_ARM: begin
                     if (ch_ok) begin
                        active_in[ch_idx] = 1'b1;
                     end
                  end
                  mcpt_pkg::OP_DISARM: begin
                     if (ch_ok) begin
                        active_in[ch_idx] = 1'b0;
                     end
                  end
                  mcpt_pkg::OP_TICK: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (active_ff[idx_ff] && alu_not_neg) begin
               active_in[idx_ff]  = 1'b0;
               expired_in[idx_ff] = 1'b1;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         active_ff    <= '0;
         expired_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         expired_ff   <= expired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: a deadline is only looked at while its channel is active
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_now_time;
         if (req_operation == mcpt_pkg::OP_ARM && ch_ok) begin
            deadline_ff[ch_idx] <= alu_res;
         end
      end
      if (state_ff == S_FIN && out_free) begin
         trig_ff <= mcpt_pkg::MASK_W'(active_ff);
         exp_ff  <= mcpt_pkg::MASK_W'(expired_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trigger_mask = trig_ff;
   assign rsp_expired_mask = exp_ff;

   a_exp_not_active: assert property (@(posedge clock) disable iff (reset)
      (expired_ff & active_ff) == '0)
      else $error("channel both expired and active");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result loaded outside finish step");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && idx_ff == IDX_LAST) |=> state_ff == S_FIN)
      else $error("scan did not end after last channel");

   a_rsp_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (trig_ff & exp_ff) == '0)
      else $error("expired channel still shown as triggered");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

typedef struct packed {
   logic [mcpt_pkg::MASK_W-1:0] trigger;
   logic [mcpt_pkg::MASK_W-1:0] expired;
} mask_pair_type;

// Tracks channel deadlines and activity, queues the masks each word should produce.
class timer_scoreboard;
   logic [mcpt_pkg::TIME_W-1:0] deadline [mcpt_pkg::CHANNELS_DEF];
   logic [mcpt_pkg::MASK_W-1:0] active_bits;
   mask_pair_type expected_masks [$];
   int mismatches;

   function new();
      foreach (deadline[i]) deadline[i] = '0;
      active_bits = '0;
      mismatches = 0;
   endfunction

   function void note_word(input logic [mcpt_pkg::OP_W-1:0] op,
                           input logic [mcpt_pkg::CH_W-1:0] ch,
                           input logic [mcpt_pkg::TIME_W-1:0] width,
                           input logic [mcpt_pkg::TIME_W-1:0] now);
      mask_pair_type p;
      logic [mcpt_pkg::TIME_W-1:0] diff;
      p.expired = '0;
      // 3-bit channel always falls below CHANNELS here
      case (op)
         mcpt_pkg::OP_ARM: begin
            deadline[ch] = now + width;
            active_bits[ch] = 1'b1;
         end
         mcpt_pkg::OP_DISARM: begin
            deadline[ch] = '0;
            active_bits[ch] = 1'b0;
         end
         mcpt_pkg::OP_TICK: begin
            for (int i = 0; i < mcpt_pkg::CHANNELS_DEF; i++) begin
               diff = now - deadline[i];
               // wrap-safe: signed difference >= 0
               if (active_bits[i] && !diff[mcpt_pkg::TIME_W-1]) begin
                  active_bits[i] = 1'b0;
                  deadline[i] = '0;
                  p.expired[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      p.trigger = active_bits;
      expected_masks.push_back(p);
   endfunction

   function void check_word(input logic [mcpt_pkg::MASK_W-1:0] trig,
                            input logic [mcpt_pkg::MASK_W-1:0] expd);
      mask_pair_type p;
      if (expected_masks.size() == 0) begin
         $error("result with no word pending: trigger_mask %h expired_mask %h", trig, expd);
         mismatches++;
      end else begin
         p = expected_masks.pop_front();
         if (trig !== p.trigger) begin
            $error("trigger_mask: expected %h, got %h", p.trigger, trig);
            mismatches++;
         end
         if (expd !== p.expired) begin
            $error("expired_mask: expected %h, got %h", p.expired, expd);
            mismatches++;
         end
      end
   endfunction

   function int pending();
      return expected_masks.size();
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 525;
   localparam logic [mcpt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [mcpt_pkg::OP_W-1:0]     req_operation;
   logic [mcpt_pkg::CH_W-1:0]     req_channel;
   logic [mcpt_pkg::TIME_W-1:0]   req_pulse_width;
   logic [mcpt_pkg::TIME_W-1:0]   req_now_time;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [mcpt_pkg::MASK_W-1:0]   rsp_trigger_mask;
   logic [mcpt_pkg::MASK_W-1:0]   rsp_expired_mask;

   timer_scoreboard sb = new();
   int cycle_count;
   bit no_gaps;
   logic [mcpt_pkg::TIME_W-1:0] clock_us;

   multi_channel_pulse_timer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_channel      (req_channel),
      .req_pulse_width  (req_pulse_width),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_trigger_mask (rsp_trigger_mask),
      .rsp_expired_mask (rsp_expired_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic [mcpt_pkg::OP_W-1:0] op,
                            input logic [mcpt_pkg::CH_W-1:0] ch,
                            input logic [mcpt_pkg::TIME_W-1:0] width,
                            input logic [mcpt_pkg::TIME_W-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_channel     <= ch;
      req_pulse_width <= width;
      req_now_time    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender goes quiet so the last word is not taken again
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // accepted words and results, sampled before this edge's updates
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_word(req_operation, req_channel, req_pulse_width, req_now_time);
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_trigger_mask, rsp_expired_mask);
      end
   end

   // receiver backpressure
   initial begin
      int hold_left;
      int r;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rsp_stall <= 1'b0;
               hold_left = $urandom_range(40, 150);
            end else if (r < 60) begin
               rsp_stall <= 1'b0;
               hold_left = $urandom_range(0, 4);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               hold_left = $urandom_range(0, 4);
            end else begin
               rsp_stall <= 1'b1;
               hold_left = $urandom_range(15, 50);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int r;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = mcpt_pkg::OP_ARM;
      req_channel     = '0;
      req_pulse_width = '0;
      req_now_time    = '0;
      no_gaps         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words
      send_word(OP_UNUSED,           3'd0, 32'hFFFF_FFFF, 32'h0);
      send_word(mcpt_pkg::OP_DISARM, 3'd5, 32'h0, 32'd10);
      send_word(mcpt_pkg::OP_ARM,    3'd0, 32'h0, 32'd1000);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'd999);
      send_word(mcpt_pkg::OP_TICK,   3'd7, 32'h0, 32'd1000);
      send_word(mcpt_pkg::OP_ARM,    3'd7, 32'hFFFF_FFFF, 32'd1000);
      // deadline wraps to zero
      send_word(mcpt_pkg::OP_ARM,    3'd1, 32'h10, 32'hFFFF_FFF0);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'hFFFF_FFFF);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'h0);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'd1000);
      // re-arm restarts the pulse
      send_word(mcpt_pkg::OP_ARM,    3'd2, 32'd100, 32'd5000);
      send_word(mcpt_pkg::OP_ARM,    3'd2, 32'd500, 32'd5050);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'd5200);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'd5550);
      // half-range distance is not yet reached, just below it is
      send_word(mcpt_pkg::OP_ARM,    3'd3, 32'h0, 32'h0);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'h8000_0000);
      send_word(mcpt_pkg::OP_TICK,   3'd0, 32'h0, 32'h7FFF_FFFF);
      send_word(mcpt_pkg::OP_ARM,    3'd4, 32'd10, 32'd100);
      send_word(mcpt_pkg::OP_ARM,    3'd5, 32'd10, 32'd100);
      send_word(mcpt_pkg::OP_ARM,    3'd6, 32'd10, 32'd100);
      send_word(mcpt_pkg::OP_DISARM, 3'd6, 32'hFFFF_FFFF, 32'd105);
      send_word(OP_UNUSED,           3'd6, 32'd0, 32'd106);
      send_word(mcpt_pkg::OP_TICK,   3'd6, 32'hFFFF_FFFF, 32'd110);

      // random words: mostly a running time base with realistic pulses
      clock_us = $urandom;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 200) clock_us = 32'hFFFF_F000;
         if (n == 300) wait_drained();
         no_gaps = (n >= 400 && n < 450);
         r = $urandom_range(0, 99);
         if (r < 45) begin
            clock_us = clock_us + $urandom_range(50, 150);
            send_word(mcpt_pkg::OP_TICK, mcpt_pkg::CH_W'($urandom_range(0, 7)), $urandom,
                      clock_us);
         end else if (r < 75) begin
            send_word(mcpt_pkg::OP_ARM, mcpt_pkg::CH_W'($urandom_range(0, 7)),
                      $urandom_range(0, 1000), clock_us + $urandom_range(0, 20));
         end else if (r < 85) begin
            send_word(mcpt_pkg::OP_DISARM, mcpt_pkg::CH_W'($urandom_range(0, 7)), $urandom,
                      clock_us);
         end else if (r < 90) begin
            send_word(mcpt_pkg::OP_ARM, mcpt_pkg::CH_W'($urandom_range(0, 7)), $urandom,
                      clock_us);
         end else if (r < 95) begin
            send_word(mcpt_pkg::OP_TICK, mcpt_pkg::CH_W'($urandom_range(0, 7)), $urandom,
                      $urandom);
         end else begin
            send_word(mcpt_pkg::OP_W'($urandom_range(0, 3)),
                      mcpt_pkg::CH_W'($urandom_range(0, 7)), $urandom, $urandom);
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (mcpt_pkg::CHANNELS_DEF + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
